// File: rtl/rcs_pkg.sv
package rcs_pkg;

  // sizing of the owner table, wait queue and thread ids
  localparam int MAX_OWNERS  = 8;
  localparam int WAIT_DEPTH  = 16;
  localparam int THREAD_BITS = 8;

  localparam int SLOT_W  = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
  localparam int HELD_W  = $clog2(MAX_OWNERS + 1);
  localparam int WPTR_W  = $clog2(WAIT_DEPTH);
  localparam int WUSED_W = $clog2(WAIT_DEPTH + 1);
  localparam int COUNT_W = 15;

  // fixed field widths
  localparam int OPCODE_W = 2;
  localparam int TID_IN_W = 8;
  localparam int STATUS_W = 3;
  localparam int OWNERS_W = 4;
  localparam int MAXC_W   = 4;

  typedef logic [THREAD_BITS-1:0] tid_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [SLOT_W-1:0]      slot_idx_t;

  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TRY     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GRANT_NEW = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GRANT_REC = 3'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd5;
  localparam logic [STATUS_W-1:0] ST_QFULL     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd7;

  typedef struct packed {
    logic   valid;
    tid_t   thread;
    count_t count;
  } slot_ent_t;

  typedef struct packed {
    logic      owner_hit;
    slot_idx_t owner_idx;
    count_t    owner_count;
    logic      free_hit;
    slot_idx_t free_idx;
  } scan_res_t;

  typedef struct packed {
    logic push;
    logic pop;
    tid_t push_tid;
  } fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

endpackage

// File: rtl/rcs_if.sv
interface rcs_req_if import rcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [TID_IN_W-1:0] thread_id;

  modport source (output valid, output opcode, output thread_id, input ready);
  modport sink   (input valid, input opcode, input thread_id, output ready);
endinterface

interface rcs_rsp_if import rcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                wake_valid;
  logic [TID_IN_W-1:0] wake_thread;
  logic [OWNERS_W-1:0] owners_now;

  modport source (output valid, output status, output wake_valid, output wake_thread,
                  output owners_now, input ready);
  modport sink   (input valid, input status, input wake_valid, input wake_thread,
                  input owners_now, output ready);
endinterface

// File: rtl/rcs_wait_fifo.sv
module rcs_wait_fifo import rcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fifo_ctl_t ctl_i,
  output fifo_sts_t sts_o,
  output tid_t      rd_data_o
);

  tid_t               mem [WAIT_DEPTH];
  tid_t               rd_q;
  logic [WPTR_W-1:0]  head_q, head_d;
  logic [WPTR_W-1:0]  tail_q, tail_d;
  logic [WUSED_W-1:0] used_q, used_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    used_d = used_q;
    if (ctl_i.push) begin
      tail_d = (32'(tail_q) + 1 >= WAIT_DEPTH) ? '0 : tail_q + WPTR_W'(1);
      used_d = used_q + WUSED_W'(1);
    end else if (ctl_i.pop) begin
      head_d = (32'(head_q) + 1 >= WAIT_DEPTH) ? '0 : head_q + WPTR_W'(1);
      used_d = used_q - WUSED_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      used_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      used_q <= used_d;
    end
  end

  // queue storage, registered read at the head on pop
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= ctl_i.push_tid;
    end
    if (ctl_i.pop) begin
      rd_q <= mem[head_q];
    end
  end

  assign sts_o.full  = (32'(used_q) >= WAIT_DEPTH);
  assign sts_o.empty = (used_q == '0);
  assign rd_data_o   = rd_q;

endmodule

// File: rtl/rcs_scan_unit.sv
module rcs_scan_unit import rcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  tid_t      key_i,
  input  slot_ent_t ent_i,
  output slot_idx_t idx_o,
  output logic      done_o,
  output scan_res_t res_o
);

  logic      busy_q;
  logic      done_q;
  slot_idx_t idx_q;
  tid_t      key_q;
  scan_res_t res_q;
  logic      hit;
  logic      free;

  // shared compare against the entry at the scan pointer
  assign hit  = ent_i.valid && (ent_i.thread == key_q);
  assign free = !ent_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      key_q  <= '0;
      res_q  <= '0;
    end else begin
      // done pulses in the cycle after the last slot is compared
      done_q <= !start_i && busy_q && (idx_q == SLOT_W'(MAX_OWNERS - 1));
      if (start_i) begin
        busy_q          <= 1'b1;
        idx_q           <= '0;
        key_q           <= key_i;
        res_q.owner_hit <= 1'b0;
        res_q.free_hit  <= 1'b0;
      end else if (busy_q) begin
        if (hit && !res_q.owner_hit) begin
          res_q.owner_hit   <= 1'b1;
          res_q.owner_idx   <= idx_q;
          res_q.owner_count <= ent_i.count;
        end
        if (free && !res_q.free_hit) begin
          res_q.free_hit <= 1'b1;
          res_q.free_idx <= idx_q;
        end
        if (idx_q == SLOT_W'(MAX_OWNERS - 1)) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + SLOT_W'(1);
        end
      end
    end
  end

  assign idx_o  = idx_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/recursive_counting_semaphore.sv
// recursive counting semaphore with a fifo of blocked requesters
//
// req channel (valid/ready): opcode and thread_id, one beat per request.
// rsp channel (valid/ready): status, wake_valid, wake_thread, owners_now,
//   exactly one beat per request, in request order.
// cfg_we_i: max_count <= cfg_data_i; user writes only while idle (unchecked).
//
// each request scans the owner table one slot per cycle through a shared
// compare unit, then passes S_OUT, where its result goes into the output
// register; only then is the next req beat taken. a final release that
// wakes a waiter reads the queue head (S_WAKE_RD) and scans the table a
// second time (S_WAKE_SCAN) before its rsp beat is registered.
// req.ready is high only between requests; one request is in work at once.
// the rsp beat sits in an output register; if the receiver stalls, the
// next request is still accepted and scanned, and its result waits until
// the output register is taken.
// reset: no owners, empty wait queue, max_count = 1, no rsp beat pending.
module recursive_counting_semaphore import rcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MAXC_W-1:0] cfg_data_i,
  rcs_req_if.sink           req,
  rcs_rsp_if.source         rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAKE_RD,
    S_WAKE_SCAN,
    S_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic [MAXC_W-1:0]   max_count_q, max_count_d;
  logic [OPCODE_W-1:0] op_q, op_d;
  tid_t                tid_q, tid_d;
  slot_idx_t           rel_idx_q, rel_idx_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                wake_q, wake_d;
  tid_t                wthread_q, wthread_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic                out_wake_q, out_wake_d;
  tid_t                out_wthread_q, out_wthread_d;
  logic [HELD_W-1:0]   out_owners_q, out_owners_d;

  // owner table
  logic   slot_valid_q [MAX_OWNERS];
  tid_t   slot_thread_q [MAX_OWNERS];
  count_t slot_count_q [MAX_OWNERS];

  logic      slot_set, slot_clr, thr_we, cnt_we;
  slot_idx_t slot_widx;
  tid_t      slot_wthread;
  count_t    slot_wcount;

  // scan unit and wait queue
  logic      scan_start;
  tid_t      scan_key;
  slot_idx_t scan_idx;
  logic      scan_done;
  scan_res_t sr;
  slot_ent_t scan_ent;
  fifo_ctl_t fifo_ctl;
  fifo_sts_t fifo_sts;
  tid_t      fifo_rd;
  logic      can_grant;
  count_t    dec_count;

  assign scan_ent.valid  = slot_valid_q[scan_idx];
  assign scan_ent.thread = slot_thread_q[scan_idx];
  assign scan_ent.count  = slot_count_q[scan_idx];

  rcs_scan_unit u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .key_i   (scan_key),
    .ent_i   (scan_ent),
    .idx_o   (scan_idx),
    .done_o  (scan_done),
    .res_o   (sr)
  );

  rcs_wait_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (fifo_ctl),
    .sts_o     (fifo_sts),
    .rd_data_o (fifo_rd)
  );

  // owner limit is min(max_count, table size)
  assign can_grant = (32'(held_q) < 32'(max_count_q)) && (32'(held_q) < MAX_OWNERS);
  assign dec_count = (sr.owner_count != '0) ? sr.owner_count - count_t'(1) : '0;

  always_comb begin
    state_d       = state_q;
    held_d        = held_q;
    max_count_d   = max_count_q;
    op_d          = op_q;
    tid_d         = tid_q;
    rel_idx_d     = rel_idx_q;
    status_d      = status_q;
    wake_d        = wake_q;
    wthread_d     = wthread_q;
    out_valid_d   = out_valid_q && !rsp.ready;
    out_status_d  = out_status_q;
    out_wake_d    = out_wake_q;
    out_wthread_d = out_wthread_q;
    out_owners_d  = out_owners_q;
    slot_set      = 1'b0;
    slot_clr      = 1'b0;
    thr_we        = 1'b0;
    cnt_we        = 1'b0;
    slot_widx     = sr.owner_idx;
    slot_wthread  = tid_q;
    slot_wcount   = sr.owner_count + count_t'(1);
    scan_start    = 1'b0;
    scan_key      = tid_q;
    fifo_ctl      = '0;
    fifo_ctl.push_tid = tid_q;

    if (cfg_we_i) begin
      max_count_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          op_d       = req.opcode;
          tid_d      = tid_t'(req.thread_id);
          scan_key   = tid_t'(req.thread_id);
          scan_start = 1'b1;
          wake_d     = 1'b0;
          wthread_d  = '0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_done) begin
          state_d = S_OUT;
          if ((op_q == OP_ACQUIRE) || (op_q == OP_TRY)) begin
            if (sr.owner_hit) begin
              // recursive grant, saturating
              if (sr.owner_count == COUNT_MAX) begin
                status_d = ST_SATURATED;
              end else begin
                cnt_we   = 1'b1;
                status_d = ST_GRANT_REC;
              end
            end else if (can_grant && sr.free_hit) begin
              slot_widx   = sr.free_idx;
              slot_set    = 1'b1;
              thr_we      = 1'b1;
              cnt_we      = 1'b1;
              slot_wcount = count_t'(1);
              held_d      = held_q + HELD_W'(1);
              status_d    = ST_GRANT_NEW;
            end else if (op_q == OP_TRY) begin
              status_d = ST_DENIED;
            end else if (fifo_sts.full) begin
              status_d = ST_QFULL;
            end else begin
              fifo_ctl.push = 1'b1;
              status_d      = ST_QUEUED;
            end
          end else if (op_q == OP_RELEASE) begin
            if (!sr.owner_hit) begin
              status_d = ST_NOT_OWNER;
            end else begin
              status_d = ST_RELEASED;
              if (dec_count == '0) begin
                // final release frees the slot, oldest waiter may take it
                slot_clr = 1'b1;
                held_d   = held_q - HELD_W'(1);
                if (!fifo_sts.empty) begin
                  fifo_ctl.pop = 1'b1;
                  rel_idx_d    = sr.owner_idx;
                  state_d      = S_WAKE_RD;
                end
              end else begin
                cnt_we      = 1'b1;
                slot_wcount = dec_count;
              end
            end
          end else begin
            // unused opcode: no state change
            status_d = ST_DENIED;
          end
        end
      end

      S_WAKE_RD: begin
        // queue head is in the read register now; look it up in the table
        scan_key   = fifo_rd;
        scan_start = 1'b1;
        wake_d     = 1'b1;
        wthread_d  = fifo_rd;
        state_d    = S_WAKE_SCAN;
      end

      S_WAKE_SCAN: begin
        if (scan_done) begin
          state_d = S_OUT;
          if (sr.owner_hit) begin
            // woken thread already owns: bump its own count, freed slot stays free
            if (sr.owner_count != COUNT_MAX) begin
              cnt_we = 1'b1;
            end
          end else begin
            slot_widx    = rel_idx_q;
            slot_wthread = wthread_q;
            slot_set     = 1'b1;
            thr_we       = 1'b1;
            cnt_we       = 1'b1;
            slot_wcount  = count_t'(1);
            held_d       = held_q + HELD_W'(1);
          end
        end
      end

      S_OUT: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d   = 1'b1;
          out_status_d  = status_q;
          out_wake_d    = wake_q;
          out_wthread_d = wthread_q;
          out_owners_d  = held_q;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      held_q        <= '0;
      max_count_q   <= MAXC_W'(1);
      op_q          <= '0;
      tid_q         <= '0;
      rel_idx_q     <= '0;
      status_q      <= ST_DENIED;
      wake_q        <= 1'b0;
      wthread_q     <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_DENIED;
      out_wake_q    <= 1'b0;
      out_wthread_q <= '0;
      out_owners_q  <= '0;
      for (int i = 0; i < MAX_OWNERS; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
    end else begin
      state_q       <= state_d;
      held_q        <= held_d;
      max_count_q   <= max_count_d;
      op_q          <= op_d;
      tid_q         <= tid_d;
      rel_idx_q     <= rel_idx_d;
      status_q      <= status_d;
      wake_q        <= wake_d;
      wthread_q     <= wthread_d;
      out_valid_q   <= out_valid_d;
      out_status_q  <= out_status_d;
      out_wake_q    <= out_wake_d;
      out_wthread_q <= out_wthread_d;
      out_owners_q  <= out_owners_d;
      if (slot_set) begin
        slot_valid_q[slot_widx] <= 1'b1;
      end else if (slot_clr) begin
        slot_valid_q[slot_widx] <= 1'b0;
      end
    end
  end

  // slot payload, undefined until written
  always_ff @(posedge clk_i) begin
    if (thr_we) begin
      slot_thread_q[slot_widx] <= slot_wthread;
    end
    if (cnt_we) begin
      slot_count_q[slot_widx] <= slot_wcount;
    end
  end

  assign req.ready       = (state_q == S_IDLE);
  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.wake_valid  = out_wake_q;
  assign rsp.wake_thread = TID_IN_W'(out_wthread_q);
  assign rsp.owners_now  = OWNERS_W'(out_owners_q);

endmodule

// File: rtl/rcs_checker.sv
module rcs_checker import rcs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic                rsp_wake_valid_i,
  input logic [TID_IN_W-1:0] rsp_wake_thread_i,
  input logic [OWNERS_W-1:0] rsp_owners_now_i
);

  // a pending rsp beat stays until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("rsp beat dropped while stalled");

  // one request in work: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("req accepted while previous request in work");

  // a wake only comes with a release
  a_wake_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_wake_valid_i |-> rsp_status_i == ST_RELEASED)
    else $error("wake reported without release");

  // no wake means wake_thread reads zero
  a_wake_thread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_wake_valid_i |-> rsp_wake_thread_i == '0)
    else $error("wake_thread set without wake");

  // owner count never exceeds the table
  a_owners_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> 32'(rsp_owners_now_i) <= MAX_OWNERS)
    else $error("owners_now beyond table size");

endmodule

bind recursive_counting_semaphore rcs_checker u_rcs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_status_i      (rsp.status),
  .rsp_wake_valid_i  (rsp.wake_valid),
  .rsp_wake_thread_i (rsp.wake_thread),
  .rsp_owners_now_i  (rsp.owners_now)
);

// File: sim/tb_recursive_counting_semaphore.sv
`timescale 1ns / 1ps

module tb_recursive_counting_semaphore;
  import rcs_pkg::*;

  // opcode value that the block must ignore
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // number of random phases and requests in each
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int POOL_SIZE    = 10;
  localparam int TAIL_CYCLES  = 2 * MAX_OWNERS + 30;
  localparam int HOLD_CYCLES  = 400;

  // one response beat as the block should produce it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                wake_valid;
    logic [TID_IN_W-1:0] wake_thread;
    logic [OWNERS_W-1:0] owners_now;
  } sem_result_t;

  // mirror of the owner table and wait queue, plus the responses still owed
  class sem_scoreboard;
    bit                owned[MAX_OWNERS];
    tid_t              owner_tid[MAX_OWNERS];
    count_t            owner_cnt[MAX_OWNERS];
    tid_t              waiters[$];
    int unsigned       held;
    logic [MAXC_W-1:0] limit;
    sem_result_t       owed_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       wakes;
    int unsigned       status_seen[8];

    function new();
      for (int i = 0; i < MAX_OWNERS; i++) owned[i] = 1'b0;
      held   = 0;
      limit  = MAXC_W'(1);
      errors = 0;
      checked = 0;
      wakes  = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
    endfunction

    function int owner_of(tid_t t);
      for (int i = 0; i < MAX_OWNERS; i++)
        if (owned[i] && owner_tid[i] == t) return i;
      return -1;
    endfunction

    function int free_slot();
      for (int i = 0; i < MAX_OWNERS; i++)
        if (!owned[i]) return i;
      return -1;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function tid_t some_owner();
      int idx[$];
      for (int i = 0; i < MAX_OWNERS; i++)
        if (owned[i]) idx.push_back(i);
      if (idx.size() == 0) return '0;
      return owner_tid[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    // predicts the response of one accepted request and updates the mirror
    function void note_request(logic [OPCODE_W-1:0] op, logic [TID_IN_W-1:0] tid_raw);
      sem_result_t r;
      tid_t        t;
      tid_t        nxt;
      int          s;
      int          f;
      int          o;
      int unsigned lim;
      t = tid_raw[THREAD_BITS-1:0];
      r.status      = ST_DENIED;
      r.wake_valid  = 1'b0;
      r.wake_thread = '0;
      lim = (limit < MAX_OWNERS) ? limit : MAX_OWNERS;
      s = owner_of(t);
      f = free_slot();
      if (op == OP_ACQUIRE || op == OP_TRY) begin
        if (s >= 0) begin
          if (owner_cnt[s] >= COUNT_MAX) begin
            r.status = ST_SATURATED;
          end else begin
            owner_cnt[s]++;
            r.status = ST_GRANT_REC;
          end
        end else if (held < lim && f >= 0) begin
          owned[f]     = 1'b1;
          owner_tid[f] = t;
          owner_cnt[f] = count_t'(1);
          held++;
          r.status = ST_GRANT_NEW;
        end else if (op == OP_TRY) begin
          r.status = ST_DENIED;
        end else if (waiters.size() >= WAIT_DEPTH) begin
          r.status = ST_QFULL;
        end else begin
          waiters.push_back(t);
          r.status = ST_QUEUED;
        end
      end else if (op == OP_RELEASE) begin
        if (s < 0) begin
          r.status = ST_NOT_OWNER;
        end else begin
          r.status = ST_RELEASED;
          if (owner_cnt[s] > 0) owner_cnt[s]--;
          if (owner_cnt[s] == 0) begin
            owned[s] = 1'b0;
            held--;
            if (waiters.size() > 0) begin
              nxt = waiters.pop_front();
              r.wake_valid  = 1'b1;
              r.wake_thread = nxt;
              o = owner_of(nxt);
              if (o >= 0) begin
                // woken thread already holds a slot: only its count moves
                if (owner_cnt[o] < COUNT_MAX) owner_cnt[o]++;
              end else begin
                owned[s]     = 1'b1;
                owner_tid[s] = nxt;
                owner_cnt[s] = count_t'(1);
                held++;
              end
            end
          end
        end
      end
      r.owners_now = OWNERS_W'(held);
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic wake_valid,
                               logic [TID_IN_W-1:0] wake_thread,
                               logic [OWNERS_W-1:0] owners_now);
      sem_result_t e;
      checked++;
      status_seen[status]++;
      if (wake_valid === 1'b1) wakes++;
      if (owed_q.size() == 0) begin
        $error("response beat with no request outstanding: status %0d", status);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (wake_valid !== e.wake_valid) begin
        $error("wake_valid: expected %0d, actual %0d", e.wake_valid, wake_valid);
        errors++;
      end
      if (wake_thread !== e.wake_thread) begin
        $error("wake_thread: expected 0x%02h, actual 0x%02h", e.wake_thread, wake_thread);
        errors++;
      end
      if (owners_now !== e.owners_now) begin
        $error("owners_now: expected %0d, actual %0d", e.owners_now, owners_now);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [MAXC_W-1:0] cfg_data_i;

  rcs_req_if req_bus ();
  rcs_rsp_if rsp_bus ();

  recursive_counting_semaphore uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_bus),
    .rsp        (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  sem_scoreboard board;

  // knobs shared between the request driver and the response sink
  int          sender_idle_pct = 0;
  int          rsp_stall_pct   = 0;
  int          rsp_hold_cycles = 0;
  int unsigned reqs_sent       = 0;
  int unsigned limit_writes    = 0;

  // small set of thread ids per phase so that owners come back often
  tid_t tid_pool[POOL_SIZE];

  // drive one request beat and wait for the block to take it
  task automatic issue(input logic [OPCODE_W-1:0] op, input logic [TID_IN_W-1:0] tid);
    // random gaps on the request side
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.opcode    <= op;
    req_bus.thread_id <= tid;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    // beat taken at this edge: predict its response now
    board.note_request(op, tid);
    reqs_sent++;
  endtask

  // stop offering and wait until every owed response has come back
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // one write of max_count; only called while the block is idle
  task automatic set_limit(input logic [MAXC_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.limit = value;
    limit_writes++;
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) tid_pool[i] = tid_t'($urandom_range(0, 255));
  endtask

  // random request, mostly well formed: releases come mostly from real owners
  task automatic pick_request(output logic [OPCODE_W-1:0] op, output logic [TID_IN_W-1:0] tid);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    tid  = tid_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 4) begin
      op  = OP_UNUSED;
      tid = TID_IN_W'($urandom_range(0, 255));
    end else if (roll < 44) begin
      op = OP_RELEASE;
      if (board.held > 0 && $urandom_range(0, 99) < 85) tid = board.some_owner();
    end else if (roll < 60) begin
      op = OP_TRY;
    end else begin
      op = OP_ACQUIRE;
      if ($urandom_range(0, 9) == 0) tid = TID_IN_W'($urandom_range(0, 255));
    end
  endtask

  // response sink: checks each beat, stalls at random or for a long hold
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_bus.valid && rsp_bus.ready)
        board.check_result(rsp_bus.status, rsp_bus.wake_valid, rsp_bus.wake_thread,
                           rsp_bus.owners_now);
      if (rsp_hold_cycles > 0) begin
        rsp_bus.ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    #100ms;
    $display("FAIL recursive_counting_semaphore");
    $finish;
  end

  initial begin
    logic [MAXC_W-1:0]   limits[PHASES];
    logic [OPCODE_W-1:0] op;
    logic [TID_IN_W-1:0] tid;
    tid_t                holder;
    tid_t                hog;

    board = new();
    limits = '{4'd3, 4'd0, 4'd8, 4'd15, 4'd1, 4'd5, 4'd2, 4'd11};

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_data_i        <= '0;
    req_bus.valid     <= 1'b0;
    req_bus.opcode    <= OP_ACQUIRE;
    req_bus.thread_id <= '0;
    rsp_bus.ready     <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, starting from the reset limit of one owner
    sender_idle_pct = 16;
    rsp_stall_pct   = 16;
    issue(OP_ACQUIRE, 8'h00);   // first grant
    issue(OP_ACQUIRE, 8'h00);   // recursive
    issue(OP_TRY, 8'hFF);       // no slot left, try is denied
    issue(OP_ACQUIRE, 8'hFF);   // queued
    issue(OP_ACQUIRE, 8'hFF);   // same thread queued twice
    issue(OP_ACQUIRE, 8'hA5);
    issue(OP_RELEASE, 8'h5A);   // release by a thread that owns nothing
    issue(OP_UNUSED, 8'h3C);    // unknown opcode, ignored
    issue(OP_RELEASE, 8'h00);
    issue(OP_RELEASE, 8'h00);   // final release wakes the head waiter
    issue(OP_RELEASE, 8'hFF);   // wakes its own duplicate entry
    issue(OP_RELEASE, 8'hFF);   // then the next waiter
    wait_idle();
    set_limit(4'd15);           // limit above the table size
    issue(OP_ACQUIRE, 8'hA5);
    for (int i = 1; i < MAX_OWNERS; i++) issue(OP_ACQUIRE, 8'(i));
    issue(OP_ACQUIRE, 8'h80);   // table full: queued
    issue(OP_TRY, 8'h40);
    wait_idle();
    set_limit(4'd2);            // lowered below the current owners
    issue(OP_RELEASE, 8'h01);   // freed slot still goes to the waiter
    issue(OP_ACQUIRE, 8'h08);
    issue(OP_RELEASE, 8'h02);

    // random phases over limits and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      set_limit(limits[p]);
      refresh_pool();
      case (p % 4)
        0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin sender_idle_pct = 85; rsp_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rsp_stall_pct = 85; end
        default: begin sender_idle_pct = 16; rsp_stall_pct = 16; end
      endcase
      // long hold on the response side so that the block backs up
      if (p == 4) rsp_hold_cycles = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender pause until everything owed is back
        if (p == 4 && n == PHASE_ITEMS / 2) wait_idle();
        pick_request(op, tid);
        issue(op, tid);
      end
    end

    // empty the table and queue, then wake a thread that already owns
    sender_idle_pct = 0;
    rsp_stall_pct   = 0;
    wait_idle();
    set_limit(MAXC_W'(MAX_OWNERS));
    while (board.held > 0) issue(OP_RELEASE, board.some_owner());
    wait_idle();
    set_limit(4'd1);
    holder = tid_t'($urandom_range(0, 255));
    hog    = holder ^ tid_t'($urandom_range(1, 255));
    issue(OP_ACQUIRE, holder);
    issue(OP_ACQUIRE, hog);     // queued behind the single slot
    wait_idle();
    set_limit(4'd2);
    issue(OP_ACQUIRE, hog);     // granted ahead of its own queue entry
    issue(OP_ACQUIRE, hog);     // recursive
    issue(OP_TRY, hog);
    issue(OP_RELEASE, holder);  // wakes a thread that already owns a slot
    issue(OP_RELEASE, hog);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests, %0d responses checked, %0d limit writes, %0d wakes",
             reqs_sent, board.checked, limit_writes, board.wakes);
    $display("status mix new/rec/queued/denied/released/not-owner/full/sat: %0d %0d %0d %0d %0d %0d %0d %0d",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3], board.status_seen[4], board.status_seen[5],
             board.status_seen[6], board.status_seen[7]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS recursive_counting_semaphore");
    end else begin
      $display("FAIL recursive_counting_semaphore");
    end
    $finish;
  end

endmodule
